/* rtl/core/amcb_pkg.sv */
// Shared types and constants for the bitmask-DP assignment core.
// Holds the control word, sequencer status and step codes.
// No dependencies; used by every module of the core.
package amcb_pkg;

    localparam int MAX_N_DEF     = 10;
    localparam int COST_BITS_DEF = 16;

    // Fixed field widths at the ports
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int COST_IN_W   = 16;
    localparam int PERSONS_W   = 4;
    localparam int MIN_COST_W  = 20;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Program step codes
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step ST_CLR  = 4'd0;
    localparam t_step ST_RDH  = 4'd1;
    localparam t_step ST_CHK  = 4'd2;
    localparam t_step ST_RDT  = 4'd3;
    localparam t_step ST_REL  = 4'd4;
    localparam t_step ST_INCJ = 4'd5;
    localparam t_step ST_NEXT = 4'd6;
    localparam t_step ST_RDF  = 4'd7;
    localparam t_step ST_OUT  = 4'd8;
    localparam t_step ST_IDLE = 4'd9;
    localparam t_step ST_LAST = ST_IDLE;

    typedef enum logic [2:0] {
        C_NONE,
        C_NO_RUN,
        C_MASK_MORE,
        C_SKIP,
        C_BIT_SET,
        C_J_MORE,
        C_OUT_BUSY
    } t_cond;

    // One microcode word
    typedef struct packed {
        logic  s_ready;    // accept input transfers
        logic  n_latch;    // latch side n, clear mask
        logic  tbl_clear;  // clearing write at mask
        logic  rd_here;    // read table at mask, latch person
        logic  rd_tgt;     // read target entry and cost
        logic  wr_rel;     // relax write if candidate is smaller
        logic  mask_step;  // mask advance, wraps at last
        logic  j_clr;
        logic  j_inc;
        logic  rd_full;    // read table at full mask
        logic  out_load;   // load result register when free
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic run_req;
        logic mask_more;
        logic skip;
        logic bit_set;
        logic j_more;
        logic out_busy;
    } t_stat;

endpackage

/* rtl/core/amcb_seq.sv */
// Microcode sequencer: step counter, program ROM and jump logic.
// Depends on amcb_pkg for the control word, status and step codes.
module amcb_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  amcb_pkg::t_stat i_stat,
    output amcb_pkg::t_ctrl o_ctl
);
    import amcb_pkg::*;

    t_step r_upc;
    t_step n_upc;
    logic  take;

    function automatic t_ctrl f_rom(input t_step s);
        t_ctrl w;
        w = '0;
        w.cond   = C_NONE;
        w.target = ST_IDLE;
        unique case (s)
            ST_CLR: begin
                w.tbl_clear = 1'b1; w.mask_step = 1'b1;
                w.cond = C_MASK_MORE; w.target = ST_CLR;
            end
            ST_RDH: begin
                w.rd_here = 1'b1; w.j_clr = 1'b1;
            end
            ST_CHK: begin
                w.cond = C_SKIP; w.target = ST_NEXT;
            end
            ST_RDT: begin
                w.rd_tgt = 1'b1;
                w.cond = C_BIT_SET; w.target = ST_INCJ;
            end
            ST_REL: begin
                w.wr_rel = 1'b1;
            end
            ST_INCJ: begin
                w.j_inc = 1'b1;
                w.cond = C_J_MORE; w.target = ST_RDT;
            end
            ST_NEXT: begin
                w.mask_step = 1'b1;
                w.cond = C_MASK_MORE; w.target = ST_RDH;
            end
            ST_RDF: begin
                w.rd_full = 1'b1;
            end
            ST_OUT: begin
                w.out_load = 1'b1;
                w.cond = C_OUT_BUSY; w.target = ST_OUT;
            end
            ST_IDLE: begin
                w.s_ready = 1'b1; w.n_latch = 1'b1;
                w.cond = C_NO_RUN; w.target = ST_IDLE;
            end
            default: begin
                w.cond = C_NONE; w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    assign o_ctl = f_rom(r_upc);

    always_comb begin
        unique case (o_ctl.cond)
            C_NONE:      take = 1'b0;
            C_NO_RUN:    take = !i_stat.run_req;
            C_MASK_MORE: take = i_stat.mask_more;
            C_SKIP:      take = i_stat.skip;
            C_BIT_SET:   take = i_stat.bit_set;
            C_J_MORE:    take = i_stat.j_more;
            C_OUT_BUSY:  take = i_stat.out_busy;
            default:     take = 1'b0;
        endcase
        priority if (take) begin
            n_upc = o_ctl.target;
        end else if (r_upc >= ST_LAST) begin
            n_upc = ST_CLR;
        end else begin
            n_upc = r_upc + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

/* rtl/core/amcb_dp.sv */
// Datapath: cost matrix RAM, DP table RAM, mask/person/task counters,
// relax adder/compare and result register. Depends on amcb_pkg.
module amcb_dp #(
    parameter int MAX_N     = amcb_pkg::MAX_N_DEF,
    parameter int COST_BITS = amcb_pkg::COST_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  amcb_pkg::t_ctrl               i_ctl,
    output amcb_pkg::t_stat               o_stat,
    input  logic                          i_cfg_valid,
    input  logic [amcb_pkg::PERSONS_W-1:0] i_cfg_data,
    input  logic                          i_s_valid,
    input  logic [amcb_pkg::ROW_W-1:0]     i_row,
    input  logic [amcb_pkg::COL_W-1:0]     i_col,
    input  logic [amcb_pkg::COST_IN_W-1:0] i_cost,
    input  logic                          i_run,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [amcb_pkg::MIN_COST_W-1:0] o_m_data
);
    import amcb_pkg::*;

    localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int N_W       = $clog2(MAX_N + 1);
    localparam int SUM_W     = COST_BITS + N_W;
    localparam int TBL_W     = SUM_W + 1;
    localparam int TBL_DEPTH = 1 << MAX_N;
    localparam int CM_DEPTH  = 1 << (2 * IDX_W);
    localparam logic [TBL_W-1:0] INF = '1;

    logic [COST_BITS-1:0] cm  [CM_DEPTH];
    logic [TBL_W-1:0]     tbl [TBL_DEPTH];

    logic [PERSONS_W-1:0] r_persons;
    logic [N_W-1:0]       r_n;
    logic [MAX_N-1:0]     r_mask;
    logic [MAX_N-1:0]     r_last;
    logic [IDX_W-1:0]     r_j;
    logic [N_W-1:0]       r_person;
    logic [TBL_W-1:0]     r_here;
    logic [TBL_W-1:0]     r_tgt;
    logic [COST_BITS-1:0] r_cost;
    logic [MAX_N-1:0]     r_wa;
    logic                 r_out_valid;
    logic [MIN_COST_W-1:0] r_out_data;

    logic [N_W-1:0]       n_sat;
    logic [MAX_N-1:0]     n_last;
    logic [MAX_N-1:0]     tgt_addr;
    logic [SUM_W-1:0]     cand;
    logic                 cand_less;
    logic                 tbl_we;
    logic [MAX_N-1:0]     tbl_wa;
    logic [TBL_W-1:0]     tbl_wd;
    logic [IDX_W-1:0]     last_j;
    logic                 s_accept;
    logic                 in_range;
    logic                 out_busy;
    logic                 res_sat;
    logic [MIN_COST_W-1:0] res;

    function automatic logic [N_W-1:0] f_popcount(input logic [MAX_N-1:0] v);
        logic [N_W-1:0] c;
        c = '0;
        for (int b = 0; b < MAX_N; b++) begin
            c = c + N_W'(v[b]);
        end
        return c;
    endfunction

    assign s_accept = i_s_valid && i_ctl.s_ready;
    assign in_range = (int'(i_row) < MAX_N) && (int'(i_col) < MAX_N);

    always_comb begin
        n_sat = (int'(r_persons) > MAX_N) ? N_W'(MAX_N) : N_W'(r_persons);
        for (int b = 0; b < MAX_N; b++) begin
            n_last[b] = (b < int'(n_sat));
        end
    end

    assign tgt_addr  = r_mask | (MAX_N'(1) << r_j);
    assign last_j    = IDX_W'(r_n - N_W'(1));
    assign cand      = r_here[SUM_W-1:0] + SUM_W'(r_cost);
    assign cand_less = {1'b0, cand} < r_tgt;
    assign out_busy  = r_out_valid && !i_m_ready;

    assign tbl_we = i_ctl.tbl_clear || (i_ctl.wr_rel && cand_less);
    assign tbl_wa = i_ctl.tbl_clear ? r_mask : r_wa;
    assign tbl_wd = i_ctl.tbl_clear ? ((r_mask == '0) ? '0 : INF) : {1'b0, cand};

    // result saturates at all ones of the output field
    assign res_sat = {{MIN_COST_W{1'b0}}, r_here} > {{TBL_W{1'b0}}, {MIN_COST_W{1'b1}}};
    assign res     = res_sat ? '1 : MIN_COST_W'(r_here);

    assign o_stat.run_req   = i_s_valid && i_run;
    assign o_stat.mask_more = (r_mask != r_last);
    assign o_stat.skip      = (r_here == INF) || (r_person >= r_n);
    assign o_stat.bit_set   = r_mask[r_j];
    assign o_stat.j_more    = (r_j != last_j);
    assign o_stat.out_busy  = out_busy;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    // memories
    always_ff @(posedge i_clk) begin
        if (s_accept && in_range) begin
            cm[{i_row[IDX_W-1:0], i_col[IDX_W-1:0]}] <= COST_BITS'(i_cost);
        end
        if (i_ctl.rd_tgt) begin
            r_cost <= cm[{r_person[IDX_W-1:0], r_j}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl[tbl_wa] <= tbl_wd;
        end
        if (i_ctl.rd_here || i_ctl.rd_full) begin
            r_here <= tbl[i_ctl.rd_full ? r_last : r_mask];
        end
        if (i_ctl.rd_tgt) begin
            r_tgt <= tbl[tgt_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_here) begin
            r_person <= f_popcount(r_mask);
        end
        if (i_ctl.rd_tgt) begin
            r_wa <= tgt_addr;
        end
        if (i_ctl.out_load && !out_busy) begin
            r_out_data <= res;
        end
    end

    // counters and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persons   <= PERSONS_W'(1);
            r_n         <= '0;
            r_last      <= '0;
            r_mask      <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_persons <= i_cfg_data;
            end
            if (i_ctl.n_latch) begin
                r_n    <= n_sat;
                r_last <= n_last;
                r_mask <= '0;
            end else if (i_ctl.mask_step) begin
                r_mask <= (r_mask == r_last) ? '0 : r_mask + MAX_N'(1);
            end
            if (i_ctl.j_clr) begin
                r_j <= '0;
            end else if (i_ctl.j_inc) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (i_ctl.out_load && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/assignment_min_cost_bitmask_dp_core.sv */
// Top level of the minimum-cost assignment core (subset DP over a bitmask).
// Depends on amcb_pkg, amcb_seq and amcb_dp.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | row, col, cost_value; tuser run
//  m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | min_cost
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | persons_in_use
//
// Entry items (run = 0) are taken one per cycle and write the cost RAM.
// A run item is written, then the sequencer owns the block: it clears every DP table entry,
// then each mask reads and checks its entry and, for each task, reads the target and cost and
// relaxes it if free, one relaxation at a time; the full-mask entry then loads the result register.
// tready stays low during a run; the result register lets new items in while a result
// waits, and a stalled m_axis holds the sequencer only at its output step.
// Reset (synchronous, active low) returns to idle with n = 1; RAMs are not cleared.
module assignment_min_cost_bitmask_dp_core #(
    parameter int MAX_N     = amcb_pkg::MAX_N_DEF,
    parameter int COST_BITS = amcb_pkg::COST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [amcb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // row[3:0], col[7:4], cost_value[23:8]
    input  logic                            i_s_axis_tuser,  // run
    // master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [amcb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // min_cost[19:0], zeros[23:20]
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [amcb_pkg::PERSONS_W-1:0]   i_cfg_data       // persons_in_use
);
    import amcb_pkg::*;

    t_ctrl ctl;
    t_stat stat;
    logic [MIN_COST_W-1:0] m_data;

    amcb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    amcb_dp #(
        .MAX_N     (MAX_N),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (i_s_axis_tvalid),
        .i_row       (i_s_axis_tdata[ROW_W-1:0]),
        .i_col       (i_s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .i_cost      (i_s_axis_tdata[ROW_W+COL_W+COST_IN_W-1:ROW_W+COL_W]),
        .i_run       (i_s_axis_tuser),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_data    (m_data)
    );

    assign o_s_axis_tready = ctl.s_ready;
    assign o_cfg_ready     = 1'b1;   // side is sampled by each run as it starts
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-MIN_COST_W){1'b0}}, m_data};

endmodule

/* rtl/core/amcb_chk.sv */
// Port-level checker for the assignment core, bound to the top level.
// Depends on amcb_pkg for port widths.
module amcb_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [amcb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("input still open after a run transfer");

    a_entry_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser) |=> o_s_axis_tready)
        else $error("entry transfer closed the input");

endmodule

bind assignment_min_cost_bitmask_dp_core amcb_chk u_amcb_chk (.*);
